>>> src/bsmm_pkg.sv
// types, codes and constants shared by the min/max stack modules
package bsmm_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 5;

  // top of an empty stack reads as all ones
  localparam logic signed [WordW-1:0] EmptyTop = '1;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // what every cell of the chain does at a clock edge
  typedef enum logic [1:0] {
    SH_HOLD = 2'b00,
    SH_PUSH = 2'b01,
    SH_POP  = 2'b10
  } shift_e;

  typedef struct packed {
    op_e                     op;
    logic signed [WordW-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic signed [WordW-1:0] popped_value;
    logic signed [WordW-1:0] top_value;
    logic signed [WordW-1:0] max_value;
    logic signed [WordW-1:0] min_value;
    logic [CountW-1:0]       entry_count;
  } out_item_t;

  // one stack slot: the word and the max/min of it and everything below
  typedef struct packed {
    logic signed [WordW-1:0] entry;
    logic signed [WordW-1:0] run_max;
    logic signed [WordW-1:0] run_min;
  } slot_t;

endpackage

>>> src/bsmm_cell.sv
// one slot of the stack chain, shifting towards or away from the top
module bsmm_cell
  import bsmm_pkg::*;
(
  input  logic   clk_i,
  input  shift_e mode_i,
  input  slot_t  above_i,
  input  slot_t  below_i,
  output slot_t  slot_o
);

  slot_t slot_q, slot_d;

  always_comb begin
    unique case (mode_i)
      SH_PUSH: slot_d = above_i;
      SH_POP:  slot_d = below_i;
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

>>> src/bsmm_head.sv
// head logic: decodes an item, builds the pushed slot and the result
module bsmm_head
  import bsmm_pkg::*;
#(
  parameter int unsigned Depth = 16,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  in_item_t        item_i,
  input  slot_t           top_i,
  input  slot_t           second_i,
  input  logic [CntW-1:0] fill_i,
  output logic [CntW-1:0] fill_o,
  output shift_e          mode_o,
  output slot_t           push_slot_o,
  output out_item_t       result_o
);

  logic                full;
  logic                empty;
  slot_t               shown;

  assign full  = (fill_i == CntW'(Depth));
  assign empty = (fill_i == '0);

  always_comb begin
    push_slot_o.entry   = item_i.value;
    push_slot_o.run_max = (!empty && (top_i.run_max > item_i.value)) ? top_i.run_max
                                                                    : item_i.value;
    push_slot_o.run_min = (!empty && (top_i.run_min < item_i.value)) ? top_i.run_min
                                                                    : item_i.value;
  end

  always_comb begin
    mode_o                = SH_HOLD;
    fill_o                = fill_i;
    shown                 = top_i;
    result_o.status       = ST_DONE;
    result_o.popped_value = '0;
    unique case (item_i.op)
      OP_PUSH: begin
        if (full) begin
          result_o.status = ST_OVERFLOW;
        end else begin
          mode_o = SH_PUSH;
          fill_o = fill_i + CntW'(1);
          shown  = push_slot_o;
        end
      end
      OP_POP: begin
        if (empty) begin
          result_o.status = ST_UNDERFLOW;
        end else begin
          mode_o                = SH_POP;
          fill_o                = fill_i - CntW'(1);
          shown                 = second_i;
          result_o.popped_value = top_i.entry;
        end
      end
      default: begin
        mode_o = SH_HOLD;
      end
    endcase

    if (fill_o == '0) begin
      result_o.top_value = EmptyTop;
      result_o.max_value = '0;
      result_o.min_value = '0;
    end else begin
      result_o.top_value = shown.entry;
      result_o.max_value = shown.run_max;
      result_o.min_value = shown.run_min;
    end

    // count carries the low bits of the fill level
    result_o.entry_count = CountW'(fill_o);
  end

endmodule

>>> src/bounded_stack_min_max.sv
// bounded stack top level: head logic, chain of slot cells and result register
// latency: a result appears in the cycle after its item is accepted
// throughput: one item per cycle unless the output stalls; slots shift in one step
// in_ready_o follows the result register: free, or being emptied in the same cycle
// reset (rst_ni low, asynchronous) empties the stack and drops any waiting result
// slot contents are not reset; only the fill level says which slots are live
module bounded_stack_min_max
  import bsmm_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // fill level: number of live slots, slot 0 is always the top
  logic [CntW-1:0] fill_q, fill_d;

  // result register
  logic      out_valid_q;
  out_item_t out_q;

  logic      in_accept;
  shift_e    mode;
  shift_e    cell_mode;
  slot_t     push_slot;
  out_item_t result;
  slot_t     slots [DEPTH];

  // next item goes in as soon as the result register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  bsmm_head #(
    .Depth (DEPTH)
  ) u_head (
    .item_i      (in_item_i),
    .top_i       (slots[0]),
    .second_i    (slots[1]),
    .fill_i      (fill_q),
    .fill_o      (fill_d),
    .mode_o      (mode),
    .push_slot_o (push_slot),
    .result_o    (result)
  );

  // chain only moves on an accepted item
  assign cell_mode = in_accept ? mode : SH_HOLD;

  // push moves every slot one place deeper, pop one place towards the top
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    slot_t above;
    slot_t below;

    if (k == 0) begin : g_top
      assign above = push_slot;
    end else begin : g_inner_above
      assign above = slots[k-1];
    end

    if (k == DEPTH - 1) begin : g_bottom
      // nothing below the deepest slot; it just keeps its word, no longer live
      assign below = slots[k];
    end else begin : g_inner_below
      assign below = slots[k+1];
    end

    bsmm_cell u_cell (
      .clk_i   (clk_i),
      .mode_i  (cell_mode),
      .above_i (above),
      .below_i (below),
      .slot_o  (slots[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // fill level never goes past the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(DEPTH))
    else $error("fill level above depth");

  // an accepted push onto a stack with room raises the fill level by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_item_i.op == OP_PUSH && fill_q != CntW'(DEPTH))
    |=> (fill_q == $past(fill_q) + CntW'(1)))
    else $error("push did not raise fill level");

  // a successful pop reports the word that was on top
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_item_i.op == OP_POP && fill_q != '0)
    |=> (out_q.popped_value == $past(slots[0].entry)))
    else $error("popped word is not the old top");

  // the new top slot after a push holds the pushed word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_item_i.op == OP_PUSH && fill_q != CntW'(DEPTH))
    |=> (slots[0].entry == $past(in_item_i.value)))
    else $error("top slot does not hold pushed word");

endmodule
